>>> rtl/sdoc_pkg.sv
// Shared types and constants of the expedited SDO client.
package sdoc_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam int NODE_W    = 7;
   localparam int CAN_ID_W  = 11;
   localparam int INDEX_W   = 16;
   localparam int SUB_W     = 8;
   localparam int WORD_W    = 32;
   localparam int SIZE_W    = 3;
   localparam int MS_W      = 16;
   localparam int FRAME_W   = 64;
   localparam int CSR_IDX_W = 1;

   localparam logic [7:0]      CMD_READ    = 8'h40;
   localparam logic [7:0]      CMD_WRITE   = 8'h23;
   localparam logic [7:0]      ABORT_MASK  = 8'hE0;
   localparam logic [7:0]      ABORT_CODE  = 8'h80;
   localparam logic [MS_W-1:0] ELAPSED_MAX = 16'hFFFF;

   localparam logic [CAN_ID_W-1:0] REQUEST_BASE_RESET  = 11'd1536;
   localparam logic [CAN_ID_W-1:0] RESPONSE_BASE_RESET = 11'd1408;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_FRAME = 2'd2,
      OP_TICK  = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REQUEST_BASE  = 1'b0,
      CSR_RESPONSE_BASE = 1'b1
   } csr_index_type;

   typedef enum logic {
      KIND_REQUEST = 1'b0,
      KIND_FINISH  = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_ABORT   = 2'd1,
      STATUS_TIMEOUT = 2'd2
   } status_type;

   // Classified input beat: data holds the request bytes of a start or the
   // received bytes of a frame.
   typedef struct packed {
      op_type              op;
      logic [NODE_W-1:0]   node;
      logic [MS_W-1:0]     limit;
      logic [CAN_ID_W-1:0] frame_id;
      logic                abort;
      logic [FRAME_W-1:0]  data;
   } cmd_type;

   typedef struct packed {
      kind_type            kind;
      logic [CAN_ID_W-1:0] tx_id;
      logic [FRAME_W-1:0]  tx_payload;
      status_type          status;
      logic [WORD_W-1:0]   read_data;
      logic [WORD_W-1:0]   abort_reason;
   } rsp_type;

   typedef struct packed {
      logic                 valid;
      logic [CSR_IDX_W-1:0] index;
      logic [CAN_ID_W-1:0]  wdata;
   } csr_type;

endpackage

>>> rtl/sdoc_queue.sv
// Small FIFO queue used between the front, the back and the result port.
module sdoc_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = sdoc_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] data_in,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] data_out
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign data_out = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= data_in;
      end
   end

endmodule

>>> rtl/sdoc_front.sv
// Front end: classifies an input beat and builds the request bytes of a start.
module sdoc_front (
   input  logic [1:0]                    op,
   input  logic [sdoc_pkg::NODE_W-1:0]   node_number,
   input  logic [sdoc_pkg::INDEX_W-1:0]  object_index,
   input  logic [sdoc_pkg::SUB_W-1:0]    object_subindex,
   input  logic [sdoc_pkg::WORD_W-1:0]   write_data,
   input  logic [sdoc_pkg::SIZE_W-1:0]   data_bytes,
   input  logic [sdoc_pkg::MS_W-1:0]     limit_ms,
   input  logic [sdoc_pkg::CAN_ID_W-1:0] frame_id,
   input  logic [sdoc_pkg::FRAME_W-1:0]  frame_payload,
   output sdoc_pkg::cmd_type             cmd
);

   logic       size_ok;
   logic [1:0] unused_bytes;
   logic [7:0] write_cmd;

   // Sizes outside one to four fall back to a full four-byte write.
   assign size_ok      = (data_bytes >= 3'd1) && (data_bytes <= 3'd4);
   assign unused_bytes = size_ok ? 2'(3'd4 - data_bytes) : 2'd0;
   assign write_cmd    = sdoc_pkg::CMD_WRITE | {4'b0000, unused_bytes, 2'b00};

   always_comb begin
      cmd.op       = sdoc_pkg::op_type'(op);
      cmd.node     = node_number;
      cmd.limit    = limit_ms;
      cmd.frame_id = frame_id;
      cmd.abort    = ((frame_payload[7:0] & sdoc_pkg::ABORT_MASK) == sdoc_pkg::ABORT_CODE);
      unique case (sdoc_pkg::op_type'(op))
         sdoc_pkg::OP_READ: begin
            cmd.data = {32'h0, object_subindex, object_index, sdoc_pkg::CMD_READ};
         end
         sdoc_pkg::OP_WRITE: begin
            cmd.data = {write_data, object_subindex, object_index, write_cmd};
         end
         default: begin
            cmd.data = frame_payload;
         end
      endcase
   end

endmodule

>>> rtl/sdoc_back.sv
// Back end: transfer state, identifier registers and result generation.
module sdoc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  sdoc_pkg::cmd_type    cmd,
   input  logic                 cmd_valid,
   output logic                 cmd_pop,
   output logic                 rsp_push,
   input  logic                 rsp_full,
   output sdoc_pkg::rsp_type    rsp,
   input  sdoc_pkg::csr_type    csr,
   output logic                 csr_ready
);

   logic                            busy_ff, busy_in;
   logic                            is_read_ff, is_read_in;
   logic [sdoc_pkg::NODE_W-1:0]     node_ff, node_in;
   logic [sdoc_pkg::MS_W-1:0]       elapsed_ff, elapsed_in;
   logic [sdoc_pkg::MS_W-1:0]       limit_ff, limit_in;
   logic [sdoc_pkg::CAN_ID_W-1:0]   req_base_ff, req_base_in;
   logic [sdoc_pkg::CAN_ID_W-1:0]   rsp_base_ff, rsp_base_in;
   logic [sdoc_pkg::CAN_ID_W-1:0]   expect_id;
   logic [sdoc_pkg::MS_W-1:0]       elapsed_next;
   logic [sdoc_pkg::WORD_W-1:0]     frame_hi;

   assign csr_ready = 1'b1;
   assign cmd_pop   = cmd_valid && !rsp_full;

   assign expect_id    = rsp_base_ff + {4'b0000, node_ff};
   assign elapsed_next = (elapsed_ff < sdoc_pkg::ELAPSED_MAX) ? elapsed_ff + 1'b1 : elapsed_ff;
   assign frame_hi     = cmd.data[63:32];

   always_comb begin
      busy_in     = busy_ff;
      is_read_in  = is_read_ff;
      node_in     = node_ff;
      elapsed_in  = elapsed_ff;
      limit_in    = limit_ff;
      req_base_in = req_base_ff;
      rsp_base_in = rsp_base_ff;
      rsp_push    = 1'b0;
      rsp         = '0;

      if (csr.valid) begin
         if (csr.index == sdoc_pkg::CSR_REQUEST_BASE) begin
            req_base_in = csr.wdata;
         end else begin
            rsp_base_in = csr.wdata;
         end
      end

      if (cmd_pop) begin
         unique case (cmd.op) inside
            sdoc_pkg::OP_READ, sdoc_pkg::OP_WRITE: begin
               // Drop starts while a transfer is open.
               if (!busy_ff) begin
                  busy_in        = 1'b1;
                  is_read_in     = (cmd.op == sdoc_pkg::OP_READ);
                  node_in        = cmd.node;
                  elapsed_in     = '0;
                  limit_in       = cmd.limit;
                  rsp_push       = 1'b1;
                  rsp.kind       = sdoc_pkg::KIND_REQUEST;
                  rsp.tx_id      = req_base_ff + {4'b0000, cmd.node};
                  rsp.tx_payload = cmd.data;
               end
            end
            sdoc_pkg::OP_FRAME: begin
               if (busy_ff && (cmd.frame_id == expect_id)) begin
                  busy_in  = 1'b0;
                  rsp_push = 1'b1;
                  rsp.kind = sdoc_pkg::KIND_FINISH;
                  if (cmd.abort) begin
                     rsp.status       = sdoc_pkg::STATUS_ABORT;
                     rsp.abort_reason = frame_hi;
                  end else begin
                     rsp.status    = sdoc_pkg::STATUS_OK;
                     rsp.read_data = is_read_ff ? frame_hi : '0;
                  end
               end
            end
            default: begin
               if (busy_ff) begin
                  elapsed_in = elapsed_next;
                  if (elapsed_next >= limit_ff) begin
                     busy_in    = 1'b0;
                     rsp_push   = 1'b1;
                     rsp.kind   = sdoc_pkg::KIND_FINISH;
                     rsp.status = sdoc_pkg::STATUS_TIMEOUT;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         is_read_ff  <= 1'b0;
         node_ff     <= '0;
         elapsed_ff  <= '0;
         limit_ff    <= '0;
         req_base_ff <= sdoc_pkg::REQUEST_BASE_RESET;
         rsp_base_ff <= sdoc_pkg::RESPONSE_BASE_RESET;
      end else begin
         busy_ff     <= busy_in;
         is_read_ff  <= is_read_in;
         node_ff     <= node_in;
         elapsed_ff  <= elapsed_in;
         limit_ff    <= limit_in;
         req_base_ff <= req_base_in;
         rsp_base_ff <= rsp_base_in;
      end
   end

   a_push_needs_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> cmd_pop)
      else $error("result beat without a command beat");

   a_request_opens: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && rsp.kind == sdoc_pkg::KIND_REQUEST) |-> !busy_ff ##1 busy_ff)
      else $error("request beat did not open a transfer");

   a_finish_closes: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && rsp.kind == sdoc_pkg::KIND_FINISH) |-> busy_ff ##1 !busy_ff)
      else $error("finish beat did not close a transfer");

   a_elapsed_idle: assert property (@(posedge clock) disable iff (reset)
      (!busy_ff && !$past(busy_ff) && !$past(reset)) |-> $stable(elapsed_ff))
      else $error("elapsed time moved while idle");

endmodule

>>> rtl/sdo_expedited_client.sv
// Top level of the expedited SDO client.
// Queue-style client for CANopen expedited SDO transfers, one at a time. Push
// read starts, write starts, received CAN frames and millisecond ticks on the
// req_ side; pop request frames to transmit and transfer-finished beats on the
// rsp_ side. The block takes one beat per cycle while req_full is low: the
// front end classifies each beat into a command queue, the back end retires
// one command per cycle against the transfer state while the result queue
// is not full, and results land in a result queue. A beat is registered in
// the command queue and its result in the result queue before it shows on
// the rsp_ ports. req_full rises only when the command queue (QUEUE_DEPTH
// beats) backs up behind a full result queue. Starts while busy, frames with
// a foreign identifier and ticks while idle produce no result. The identifier
// base registers are written over the csr_ port, which is always ready.
module sdo_expedited_client #(
   parameter int QUEUE_DEPTH = sdoc_pkg::QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [1:0]                        req_op,
   input  logic [sdoc_pkg::NODE_W-1:0]       req_node_number,
   input  logic [sdoc_pkg::INDEX_W-1:0]      req_object_index,
   input  logic [sdoc_pkg::SUB_W-1:0]        req_object_subindex,
   input  logic [sdoc_pkg::WORD_W-1:0]       req_write_data,
   input  logic [sdoc_pkg::SIZE_W-1:0]       req_data_bytes,
   input  logic [sdoc_pkg::MS_W-1:0]         req_limit_ms,
   input  logic [sdoc_pkg::CAN_ID_W-1:0]     req_frame_id,
   input  logic [sdoc_pkg::FRAME_W-1:0]      req_frame_payload,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic                              rsp_out_kind,
   output logic [sdoc_pkg::CAN_ID_W-1:0]     rsp_tx_id,
   output logic [sdoc_pkg::FRAME_W-1:0]      rsp_tx_payload,
   output logic [1:0]                        rsp_finish_status,
   output logic [sdoc_pkg::WORD_W-1:0]       rsp_read_data,
   output logic [sdoc_pkg::WORD_W-1:0]       rsp_abort_reason,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sdoc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sdoc_pkg::CAN_ID_W-1:0]     csr_wdata
);

   localparam int CMD_W = $bits(sdoc_pkg::cmd_type);
   localparam int RSP_W = $bits(sdoc_pkg::rsp_type);

   sdoc_pkg::cmd_type cmd_in, cmd_head;
   sdoc_pkg::rsp_type rsp_in, rsp_head;
   sdoc_pkg::csr_type csr;
   logic              cmd_empty, cmd_pop;
   logic              rsp_push, rsp_full;

   assign csr.valid = csr_valid;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   sdoc_front u_front (
      .op              (req_op),
      .node_number     (req_node_number),
      .object_index    (req_object_index),
      .object_subindex (req_object_subindex),
      .write_data      (req_write_data),
      .data_bytes      (req_data_bytes),
      .limit_ms        (req_limit_ms),
      .frame_id        (req_frame_id),
      .frame_payload   (req_frame_payload),
      .cmd             (cmd_in)
   );

   sdoc_queue #(.WIDTH(CMD_W), .DEPTH(QUEUE_DEPTH)) u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .full     (req_full),
      .data_in  (cmd_in),
      .pop      (cmd_pop),
      .empty    (cmd_empty),
      .data_out (cmd_head)
   );

   sdoc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd_head),
      .cmd_valid (!cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_push  (rsp_push),
      .rsp_full  (rsp_full),
      .rsp       (rsp_in),
      .csr       (csr),
      .csr_ready (csr_ready)
   );

   sdoc_queue #(.WIDTH(RSP_W), .DEPTH(QUEUE_DEPTH)) u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (rsp_push),
      .full     (rsp_full),
      .data_in  (rsp_in),
      .pop      (rsp_pop),
      .empty    (rsp_empty),
      .data_out (rsp_head)
   );

   assign rsp_out_kind      = rsp_head.kind;
   assign rsp_tx_id         = rsp_head.tx_id;
   assign rsp_tx_payload    = rsp_head.tx_payload;
   assign rsp_finish_status = rsp_head.status;
   assign rsp_read_data     = rsp_head.read_data;
   assign rsp_abort_reason  = rsp_head.abort_reason;

endmodule
